// ----- rtl/core/wlfc_pkg.sv -----
// Shared types, constants and codes of the window/level false-color mapper.
package wlfc_pkg;

	localparam int LEVELS_DEF   = 256;
	localparam int PALETTES_DEF = 8;

	localparam int LANES    = 3;
	localparam int SAMPLE_W = 32;
	localparam int GAIN_W   = 16;
	localparam int SPAN_W   = 31;
	localparam int FRAC_W   = 8;
	localparam int DIV_W    = SPAN_W + FRAC_W;
	localparam int PROD_W   = SAMPLE_W + GAIN_W + 1;
	localparam int DIFF_W   = PROD_W + 1;
	localparam int RGB_W    = 24;
	localparam int LEVEL_W  = 8;
	localparam int PAL_W    = 3;
	localparam int CFG_W    = 32;
	localparam int CIDX_W   = 3;

	localparam logic [GAIN_W-1:0] GAIN_ONE = GAIN_W'(1 << FRAC_W);

	typedef enum logic [1:0] {
		OP_MONO  = 2'd0,
		OP_COLOR = 2'd1,
		OP_TABLE = 2'd2,
		OP_NONE  = 2'd3
	} opcode_t;

	typedef enum logic [CIDX_W-1:0] {
		REG_WINDOW_LOW  = 3'd0,
		REG_WINDOW_SPAN = 3'd1,
		REG_RED_GAIN    = 3'd2,
		REG_GREEN_GAIN  = 3'd3,
		REG_BLUE_GAIN   = 3'd4,
		REG_HL_ENABLE   = 3'd5,
		REG_HL_COLOR    = 3'd6,
		REG_PAL_SELECT  = 3'd7
	} cfg_reg_t;

	typedef struct packed {
		opcode_t                     opcode;
		logic signed [SAMPLE_W-1:0]  sample_first;
		logic signed [SAMPLE_W-1:0]  sample_second;
		logic signed [SAMPLE_W-1:0]  sample_third;
		logic [LEVEL_W-1:0]          table_level;
		logic [PAL_W-1:0]            table_palette;
		logic [RGB_W-1:0]            table_rgb;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_red;
		logic [7:0] out_green;
		logic [7:0] out_blue;
		logic [7:0] level_red;
		logic [7:0] level_green;
		logic [7:0] level_blue;
	} out_item_t;

	// Settings seen by the datapath; divisor is the window span times 256.
	typedef struct packed {
		logic signed [SAMPLE_W-1:0]     low;
		logic [DIV_W-1:0]               divisor;
		logic [LANES-1:0][GAIN_W-1:0]   gain;
		logic                           hl_enable;
		logic [RGB_W-1:0]               hl_color;
		logic [PAL_W-1:0]               pal_select;
	} cfg_t;

	// Sideband that travels with each beat down the pipeline.
	typedef struct packed {
		logic                valid;
		opcode_t             op;
		logic [LEVEL_W-1:0]  tbl_level;
		logic [PAL_W-1:0]    tbl_palette;
		logic [RGB_W-1:0]    tbl_rgb;
		logic [LANES-1:0]    sat;
		logic [LANES-1:0]    neg;
	} ctl_t;

endpackage

// ----- rtl/core/window_level_false_color_mapper.sv -----
// Top level of the window/level false-color mapper pipeline.
//
//   channel   signals                              carries
//   in        in_valid, in_stall, in_data          pixel or palette write beat
//   out       out_valid, out_stall, out_data       mapped pixel beat
//   cfg       cfg_we, cfg_index, cfg_data          register write, no wait
//
// One beat enters per cycle while the output is not stalled; the pipeline is three
// front stages, one restoring divide stage per index bit, a palette read stage and
// the output register.
// Reset clears the valid bits and configuration registers; palette memory is not cleared.
// A stalled output beat freezes the whole pipeline, which then stalls input.
module window_level_false_color_mapper #(
	parameter int LEVELS   = wlfc_pkg::LEVELS_DEF,
	parameter int PALETTES = wlfc_pkg::PALETTES_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  wlfc_pkg::in_item_t             in_data,
	output logic                           out_valid,
	input  logic                           out_stall,
	output wlfc_pkg::out_item_t            out_data,
	input  logic                           cfg_we,
	input  logic [wlfc_pkg::CIDX_W-1:0]    cfg_index,
	input  logic [wlfc_pkg::CFG_W-1:0]     cfg_data
);
	import wlfc_pkg::*;

	localparam int LB = $clog2(LEVELS);
	localparam int NW = DIV_W + LB;

	logic signed [SAMPLE_W-1:0]   low_q;
	logic [SPAN_W-1:0]            span_q;
	logic [LANES-1:0][GAIN_W-1:0] gain_q;
	logic                         hl_en_q;
	logic [RGB_W-1:0]             hl_color_q;
	logic [PAL_W-1:0]             psel_q;

	cfg_t          cfg;
	logic          en;
	ctl_t          ctl_d [LB+1];
	logic [NW-1:0] rem_d [LB+1][LANES];
	logic [LB-1:0] quo_d [LB+1][LANES];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_q      <= '0;
			span_q     <= SPAN_W'(255);
			gain_q     <= {LANES{GAIN_ONE}};
			hl_en_q    <= 1'b0;
			hl_color_q <= RGB_W'(24'hFF0000);
			psel_q     <= '0;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_WINDOW_LOW:  low_q      <= cfg_data;
				REG_WINDOW_SPAN: span_q     <= cfg_data[SPAN_W-1:0];
				REG_RED_GAIN:    gain_q[2]  <= cfg_data[GAIN_W-1:0];
				REG_GREEN_GAIN:  gain_q[1]  <= cfg_data[GAIN_W-1:0];
				REG_BLUE_GAIN:   gain_q[0]  <= cfg_data[GAIN_W-1:0];
				REG_HL_ENABLE:   hl_en_q    <= cfg_data[0];
				REG_HL_COLOR:    hl_color_q <= cfg_data[RGB_W-1:0];
				REG_PAL_SELECT:  psel_q     <= cfg_data[PAL_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		cfg.low        = low_q;
		// a zero span counts as one
		cfg.divisor    = {(span_q == '0) ? SPAN_W'(1) : span_q, FRAC_W'(0)};
		cfg.gain       = gain_q;
		cfg.hl_enable  = hl_en_q;
		cfg.hl_color   = hl_color_q;
		cfg.pal_select = psel_q;
	end

	assign en       = !out_valid || !out_stall;
	assign in_stall = !en;

	wlfc_front #(.LEVELS(LEVELS)) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_valid(in_valid),
		.in_data (in_data),
		.cfg     (cfg),
		.ctl_s3  (ctl_d[0]),
		.num_s3  (rem_d[0])
	);

	always_comb begin
		for (int l = 0; l < LANES; l++) begin
			quo_d[0][l] = '0;
		end
	end

	for (genvar k = 0; k < LB; k++) begin : g_div
		wlfc_div_step #(.LEVELS(LEVELS), .SHIFT(LB - 1 - k)) u_step (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (en),
			.divisor(cfg.divisor),
			.ctl_in (ctl_d[k]),
			.rem_in (rem_d[k]),
			.quo_in (quo_d[k]),
			.ctl_s1 (ctl_d[k+1]),
			.rem_s1 (rem_d[k+1]),
			.quo_s1 (quo_d[k+1])
		);
	end

	wlfc_lut #(.LEVELS(LEVELS), .PALETTES(PALETTES)) u_lut (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.cfg      (cfg),
		.ctl_in   (ctl_d[LB]),
		.quo_in   (quo_d[LB]),
		.out_valid(out_valid),
		.out_data (out_data)
	);

	// a lane cannot be both below and above the window
	a_sat_neg_excl: assert property (@(posedge clk) disable iff (!arst_n)
		ctl_d[LB].valid |-> ((ctl_d[LB].sat & ctl_d[LB].neg) == '0))
		else $error("lane flagged both saturated and negative");

	// the pipeline holds its beats while the output is stalled
	a_front_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(ctl_d[0]))
		else $error("pipeline advanced during output stall");

	a_level_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (int'(out_data.level_red) <= LEVELS - 1)
			&& (int'(out_data.level_green) <= LEVELS - 1)
			&& (int'(out_data.level_blue) <= LEVELS - 1))
		else $error("level beyond top index");

endmodule

// ----- rtl/core/wlfc_front.sv -----
// Gain multiply, window offset and range check: three pipeline stages.
module wlfc_front #(
	parameter int LEVELS = wlfc_pkg::LEVELS_DEF,
	localparam int NW = wlfc_pkg::DIV_W + $clog2(LEVELS)
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic               in_valid,
	input  wlfc_pkg::in_item_t in_data,
	input  wlfc_pkg::cfg_t     cfg,
	output wlfc_pkg::ctl_t     ctl_s3,
	output logic [NW-1:0]      num_s3 [wlfc_pkg::LANES]
);
	import wlfc_pkg::*;

	ctl_t                      ctl_s1, ctl_s2;
	ctl_t                      ctl_n2;
	logic signed [PROD_W-1:0]  prod_s1 [LANES];
	logic signed [DIFF_W-1:0]  diff_s2 [LANES];
	logic signed [SAMPLE_W-1:0] sample [LANES];
	logic [GAIN_W-1:0]         gain [LANES];
	logic signed [DIFF_W-1:0]  offset;
	logic signed [DIFF_W-1:0]  limit;

	always_comb begin
		sample[0] = in_data.sample_first;
		sample[1] = in_data.sample_second;
		sample[2] = in_data.sample_third;
		for (int l = 0; l < LANES; l++) begin
			gain[l] = (in_data.opcode == OP_MONO) ? GAIN_ONE : cfg.gain[LANES-1-l];
		end
		offset = {{(DIFF_W-SAMPLE_W-FRAC_W){cfg.low[SAMPLE_W-1]}}, cfg.low, FRAC_W'(0)};
		limit  = {{(DIFF_W-DIV_W){1'b0}}, cfg.divisor};
		ctl_n2 = ctl_s2;
		for (int l = 0; l < LANES; l++) begin
			ctl_n2.neg[l] = diff_s2[l] < 0;
			ctl_n2.sat[l] = diff_s2[l] >= limit;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			ctl_s2 <= '0;
			ctl_s3 <= '0;
		end else if (en) begin
			ctl_s1.valid       <= in_valid;
			ctl_s1.op          <= in_data.opcode;
			ctl_s1.tbl_level   <= in_data.table_level;
			ctl_s1.tbl_palette <= in_data.table_palette;
			ctl_s1.tbl_rgb     <= in_data.table_rgb;
			ctl_s1.sat         <= '0;
			ctl_s1.neg         <= '0;
			ctl_s2 <= ctl_s1;
			ctl_s3 <= ctl_n2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int l = 0; l < LANES; l++) begin
				prod_s1[l] <= PROD_W'(sample[l] * $signed({1'b0, gain[l]}));
				diff_s2[l] <= {prod_s1[l][PROD_W-1], prod_s1[l]} - offset;
				// scale the in-window remainder by the top index
				num_s3[l]  <= NW'(diff_s2[l][DIV_W-1:0]) * NW'(LEVELS - 1);
			end
		end
	end

endmodule

// ----- rtl/core/wlfc_div_step.sv -----
// One restoring divide stage: resolves one index bit on all three lanes.
module wlfc_div_step #(
	parameter int LEVELS = wlfc_pkg::LEVELS_DEF,
	parameter int SHIFT  = 0,
	localparam int LB = $clog2(LEVELS),
	localparam int NW = wlfc_pkg::DIV_W + LB
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic [wlfc_pkg::DIV_W-1:0] divisor,
	input  wlfc_pkg::ctl_t    ctl_in,
	input  logic [NW-1:0]     rem_in [wlfc_pkg::LANES],
	input  logic [LB-1:0]     quo_in [wlfc_pkg::LANES],
	output wlfc_pkg::ctl_t    ctl_s1,
	output logic [NW-1:0]     rem_s1 [wlfc_pkg::LANES],
	output logic [LB-1:0]     quo_s1 [wlfc_pkg::LANES]
);
	import wlfc_pkg::*;

	logic [NW-1:0] dsh;
	logic [NW:0]   trial [LANES];
	logic [LB-1:0] quo_nx [LANES];

	always_comb begin
		dsh = NW'(divisor) << SHIFT;
		for (int l = 0; l < LANES; l++) begin
			trial[l]  = {1'b0, rem_in[l]} - {1'b0, dsh};
			quo_nx[l] = quo_in[l];
			if (!trial[l][NW]) begin
				quo_nx[l][SHIFT] = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else if (en) begin
			ctl_s1 <= ctl_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int l = 0; l < LANES; l++) begin
				quo_s1[l] <= quo_nx[l];
				// keep the difference when no borrow
				if (!trial[l][NW]) begin
					rem_s1[l] <= trial[l][NW-1:0];
				end else begin
					rem_s1[l] <= rem_in[l];
				end
			end
		end
	end

endmodule

// ----- rtl/core/wlfc_lut.sv -----
// Index clamp, palette memory and highlight: two stages ending in the output register.
module wlfc_lut #(
	parameter int LEVELS   = wlfc_pkg::LEVELS_DEF,
	parameter int PALETTES = wlfc_pkg::PALETTES_DEF,
	localparam int LB = $clog2(LEVELS)
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  wlfc_pkg::cfg_t      cfg,
	input  wlfc_pkg::ctl_t      ctl_in,
	input  logic [LB-1:0]       quo_in [wlfc_pkg::LANES],
	output logic                out_valid,
	output wlfc_pkg::out_item_t out_data
);
	import wlfc_pkg::*;

	localparam int DEPTH = LEVELS * PALETTES;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam logic [LB-1:0] TOP = LB'(LEVELS - 1);

	logic [RGB_W-1:0] mem [DEPTH];

	ctl_t             ctl_s1;
	logic [LB-1:0]    lvl_s1 [LANES];
	logic [RGB_W-1:0] rd_s1;
	logic             pal_ok_s1;
	logic [LB-1:0]    lvl [LANES];
	logic [AW-1:0]    raddr, waddr;
	logic             we;
	logic             pal_ok;
	logic [RGB_W-1:0] rgb;
	logic             sat;
	logic             pix;

	always_comb begin
		for (int l = 0; l < LANES; l++) begin
			if (ctl_in.sat[l]) begin
				lvl[l] = TOP;
			end else if (ctl_in.neg[l]) begin
				lvl[l] = '0;
			end else begin
				lvl[l] = quo_in[l];
			end
		end
		pal_ok = int'(cfg.pal_select) < PALETTES;
		raddr  = AW'(int'(cfg.pal_select) * LEVELS + int'(lvl[0]));
		waddr  = AW'(int'(ctl_in.tbl_palette) * LEVELS + int'(ctl_in.tbl_level));
		we     = ctl_in.valid && (ctl_in.op == OP_TABLE)
			&& (int'(ctl_in.tbl_level) < LEVELS) && (int'(ctl_in.tbl_palette) < PALETTES);
	end

	// writes and reads share one stage, so table updates stay in stream order
	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem[waddr] <= ctl_in.tbl_rgb;
			end
			rd_s1 <= mem[raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1    <= '0;
			out_valid <= 1'b0;
		end else if (en) begin
			ctl_s1    <= ctl_in;
			out_valid <= pix;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pal_ok_s1 <= pal_ok;
			for (int l = 0; l < LANES; l++) begin
				lvl_s1[l] <= lvl[l];
			end
		end
	end

	always_comb begin
		pix = 1'b0;
		rgb = '0;
		sat = 1'b0;
		case (ctl_s1.op)
			OP_MONO: begin
				pix = ctl_s1.valid;
				rgb = pal_ok_s1 ? rd_s1 : '0;
				sat = lvl_s1[0] == TOP;
			end
			OP_COLOR: begin
				pix = ctl_s1.valid;
				rgb = {8'(lvl_s1[0]), 8'(lvl_s1[1]), 8'(lvl_s1[2])};
				sat = (lvl_s1[0] == TOP) || (lvl_s1[1] == TOP) || (lvl_s1[2] == TOP);
			end
			default: begin
				pix = 1'b0;
			end
		endcase
		if (cfg.hl_enable && sat) begin
			rgb = cfg.hl_color;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_data.out_red     <= rgb[23:16];
			out_data.out_green   <= rgb[15:8];
			out_data.out_blue    <= rgb[7:0];
			out_data.level_red   <= 8'(lvl_s1[0]);
			out_data.level_green <= (ctl_s1.op == OP_MONO) ? 8'(lvl_s1[0]) : 8'(lvl_s1[1]);
			out_data.level_blue  <= (ctl_s1.op == OP_MONO) ? 8'(lvl_s1[0]) : 8'(lvl_s1[2]);
		end
	end

endmodule

// ----- tb/window_level_pixel_checker.sv -----
// Checker for the window/level false-color mapper: predicts each pixel beat and compares.
`timescale 1ns / 100ps

module window_level_pixel_checker (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	input  logic                        in_stall,
	input  wlfc_pkg::in_item_t          in_data,
	input  logic                        out_valid,
	input  logic                        out_stall,
	input  wlfc_pkg::out_item_t         out_data,
	input  logic                        cfg_we,
	input  logic [wlfc_pkg::CIDX_W-1:0] cfg_index,
	input  logic [wlfc_pkg::CFG_W-1:0]  cfg_data,
	output int                          errors,
	output int                          pending
);
	import wlfc_pkg::*;

	localparam int TOP_LEVEL = LEVELS_DEF - 1;

	logic signed [31:0] low_q;
	logic [30:0]        span_q;
	logic [15:0]        gain_q [3];
	logic               hl_en_q;
	logic [23:0]        hl_color_q;
	logic [2:0]         pal_sel_q;
	logic [23:0]        palette_mem [LEVELS_DEF*PALETTES_DEF];

	out_item_t expected_pixels [$];

	string field_names [6] = '{"out_red", "out_green", "out_blue",
		"level_red", "level_green", "level_blue"};

	assign pending = expected_pixels.size();

	function automatic logic [7:0] level_of(logic signed [31:0] s, logic [15:0] g);
		longint span, diff, q;
		span = (span_q == 0) ? 1 : longint'(span_q);
		diff = longint'(s) * longint'(g) - longint'(low_q) * 256;
		q = (diff * TOP_LEVEL) / (span * 256);
		if (q > TOP_LEVEL) q = TOP_LEVEL;
		if (q < 0) q = 0;
		return q[7:0];
	endfunction

	function automatic out_item_t predict_pixel(in_item_t it);
		out_item_t r;
		logic [23:0] rgb;
		logic        sat;
		if (it.opcode == OP_MONO) begin
			r.level_red = level_of(it.sample_first, GAIN_ONE);
			r.level_green = r.level_red;
			r.level_blue = r.level_red;
			sat = (r.level_red == TOP_LEVEL);
			rgb = palette_mem[pal_sel_q * LEVELS_DEF + r.level_red];
		end else begin
			r.level_red = level_of(it.sample_first, gain_q[0]);
			r.level_green = level_of(it.sample_second, gain_q[1]);
			r.level_blue = level_of(it.sample_third, gain_q[2]);
			sat = (r.level_red == TOP_LEVEL) || (r.level_green == TOP_LEVEL)
				|| (r.level_blue == TOP_LEVEL);
			rgb = {r.level_red, r.level_green, r.level_blue};
		end
		if (hl_en_q && sat) rgb = hl_color_q;
		{r.out_red, r.out_green, r.out_blue} = rgb;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		out_item_t exp_px;
		logic [47:0] e, a;
		int bad;
		if (!arst_n) begin
			low_q <= 0;
			span_q <= 31'd255;
			gain_q <= '{GAIN_ONE, GAIN_ONE, GAIN_ONE};
			hl_en_q <= 1'b0;
			hl_color_q <= 24'hFF0000;
			pal_sel_q <= 3'd0;
			errors <= 0;
			expected_pixels.delete();
		end else begin
			if (cfg_we) begin
				case (cfg_reg_t'(cfg_index))
					REG_WINDOW_LOW:  low_q <= cfg_data;
					REG_WINDOW_SPAN: span_q <= cfg_data[30:0];
					REG_RED_GAIN:    gain_q[0] <= cfg_data[15:0];
					REG_GREEN_GAIN:  gain_q[1] <= cfg_data[15:0];
					REG_BLUE_GAIN:   gain_q[2] <= cfg_data[15:0];
					REG_HL_ENABLE:   hl_en_q <= cfg_data[0];
					REG_HL_COLOR:    hl_color_q <= cfg_data[23:0];
					REG_PAL_SELECT:  pal_sel_q <= cfg_data[2:0];
					default: ;
				endcase
			end
			// retire the output beat before queuing the new input beat
			if (out_valid && !out_stall) begin
				if (expected_pixels.size() == 0) begin
					$display("%0t: unexpected output beat %h", $time, out_data);
					errors <= errors + 1;
				end else begin
					exp_px = expected_pixels.pop_front();
					e = exp_px;
					a = out_data;
					bad = 0;
					for (int k = 0; k < 6; k++) begin
						if (e[47-8*k -: 8] !== a[47-8*k -: 8]) begin
							$display("%0t: %s expected %0d actual %0d", $time,
								field_names[k], e[47-8*k -: 8], a[47-8*k -: 8]);
							bad++;
						end
					end
					errors <= errors + bad;
				end
			end
			if (in_valid && !in_stall) begin
				case (in_data.opcode)
					OP_MONO, OP_COLOR: expected_pixels.push_back(predict_pixel(in_data));
					OP_TABLE: palette_mem[in_data.table_palette * LEVELS_DEF
						+ in_data.table_level] = in_data.table_rgb;
					default: ;
				endcase
			end
		end
	end

endmodule

// ----- tb/window_level_false_color_mapper_tb.sv -----
// Testbench top: stimulus, backpressure and verdict for the false-color mapper.
`timescale 1ns / 100ps

module window_level_false_color_mapper_tb;
	import wlfc_pkg::*;

	localparam int IDLE_LIMIT = 3000;
	localparam int DRAIN_WAIT = 30;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	in_item_t    in_data;
	logic        out_valid;
	logic        out_stall;
	out_item_t   out_data;
	logic        cfg_we;
	logic [2:0]  cfg_index;
	logic [31:0] cfg_data;
	int          errors;
	int          pending;

	// stimulus-side copy of the window, used only to aim samples
	longint win_low, win_span;
	longint gain_now [3];
	bit     calm;
	bit     hold_req;
	int     idle_cycles;

	window_level_false_color_mapper dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	window_level_pixel_checker pixel_chk (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.errors(errors), .pending(pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// receiver backpressure
	initial begin
		int stall_left;
		stall_left = 0;
		out_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				stall_left = 400;
			end
			if (stall_left > 0) begin
				out_stall <= 1'b1;
				stall_left--;
			end else begin
				out_stall <= 1'b0;
				if (!calm && $urandom_range(0, 99) < 25)
					stall_left = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 60)
						: $urandom_range(1, 4);
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	task automatic send_beat(in_item_t it);
		in_valid <= 1'b1;
		in_data <= it;
		do @(posedge clk); while (in_stall);
		if (!calm) begin
			int r;
			r = $urandom_range(0, 99);
			if (r >= 65) begin
				in_valid <= 1'b0;
				repeat ((r < 95) ? $urandom_range(1, 3) : $urandom_range(20, 60))
					@(posedge clk);
			end
		end
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
	endtask

	task automatic write_reg(cfg_reg_t idx, logic [31:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		case (idx)
			REG_WINDOW_LOW:  win_low = longint'($signed(val));
			REG_WINDOW_SPAN: win_span = (val[30:0] == 0) ? 1 : longint'(val[30:0]);
			REG_RED_GAIN:    gain_now[0] = val[15:0];
			REG_GREEN_GAIN:  gain_now[1] = val[15:0];
			REG_BLUE_GAIN:   gain_now[2] = val[15:0];
			default: ;
		endcase
	endtask

	task automatic set_window(logic [31:0] low, logic [31:0] span, logic [15:0] gr,
			logic [15:0] gg, logic [15:0] gb, logic hl, logic [23:0] color,
			logic [2:0] sel);
		write_reg(REG_WINDOW_LOW, low);
		write_reg(REG_WINDOW_SPAN, span);
		write_reg(REG_RED_GAIN, gr);
		write_reg(REG_GREEN_GAIN, gg);
		write_reg(REG_BLUE_GAIN, gb);
		write_reg(REG_HL_ENABLE, hl);
		write_reg(REG_HL_COLOR, color);
		write_reg(REG_PAL_SELECT, sel);
		cfg_we <= 1'b0;
	endtask

	// pick one of the two loaded palettes
	function automatic logic [2:0] loaded_palette();
		return ($urandom_range(0, 1) != 0) ? 3'(PALETTES_DEF - 1) : 3'd0;
	endfunction

	// aim a sample around the window edges and interior, scaled back by the gain, or pick a random or extreme value
	function automatic logic [31:0] aim_sample(longint g);
		longint t;
		int k;
		k = $urandom_range(0, 9);
		if (k <= 4) t = win_low + (win_span * $urandom_range(0, 1000)) / 1000;
		else if (k == 5) t = win_low + win_span + $urandom_range(0, 4) - 2;
		else if (k == 6) t = win_low + $urandom_range(0, 4) - 2;
		else if (k <= 8) return $urandom;
		else return ($urandom_range(0, 1) != 0) ? 32'h7FFF_FFFF : 32'h8000_0000;
		if (g != 0 && g != 256) t = (t * 256) / g;
		if (t > 64'sd2147483647) t = 64'sd2147483647;
		if (t < -64'sd2147483648) t = -64'sd2147483648;
		return t[31:0];
	endfunction

	function automatic in_item_t random_beat();
		in_item_t it;
		int r;
		it.table_level = $urandom;
		it.table_palette = $urandom;
		it.table_rgb = $urandom;
		r = $urandom_range(0, 99);
		it.opcode = (r < 45) ? OP_MONO : (r < 80) ? OP_COLOR : (r < 95) ? OP_TABLE : OP_NONE;
		it.sample_first = aim_sample((it.opcode == OP_COLOR) ? gain_now[0] : 256);
		it.sample_second = (it.opcode == OP_COLOR) ? aim_sample(gain_now[1]) : $urandom;
		it.sample_third = (it.opcode == OP_COLOR) ? aim_sample(gain_now[2]) : $urandom;
		return it;
	endfunction

	function automatic in_item_t make_beat(opcode_t op, logic [31:0] a, logic [31:0] b,
			logic [31:0] c, logic [7:0] lvl, logic [2:0] pal, logic [23:0] rgb);
		in_item_t it;
		it = '{op, a, b, c, lvl, pal, rgb};
		return it;
	endfunction

	initial begin
		in_item_t it;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		cfg_we = 1'b0;
		cfg_index = REG_WINDOW_LOW;
		cfg_data = '0;
		calm = 1'b0;
		hold_req = 1'b0;
		idle_cycles = 0;
		win_low = 0;
		win_span = 255;
		gain_now = '{256, 256, 256};
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// load the first and last palettes; mono beats only ever select these two
		calm = 1'b1;
		for (int p = 0; p < PALETTES_DEF; p += PALETTES_DEF - 1)
			for (int l = 0; l < LEVELS_DEF; l++)
				send_beat(make_beat(OP_TABLE, $urandom, $urandom, $urandom, 8'(l), 3'(p),
					24'($urandom)));
		calm = 1'b0;

		// directed: field extremes, every opcode, edge entries of the table
		send_beat(make_beat(OP_TABLE, 0, 0, 0, 8'd0, 3'd0, 24'h000000));
		send_beat(make_beat(OP_TABLE, 0, 0, 0, 8'd255, 3'd0, 24'hFFFFFF));
		send_beat(make_beat(OP_MONO, 0, 0, 0, 0, 0, 0));
		send_beat(make_beat(OP_MONO, 255, 0, 0, 0, 0, 0));
		send_beat(make_beat(OP_MONO, 254, 0, 0, 0, 0, 0));
		send_beat(make_beat(OP_MONO, -1, 0, 0, 0, 0, 0));
		send_beat(make_beat(OP_MONO, 32'h7FFF_FFFF, -1, -1, 8'hFF, 3'd7, 24'hFFFFFF));
		send_beat(make_beat(OP_MONO, 32'h8000_0000, 0, 0, 0, 0, 0));
		send_beat(make_beat(OP_COLOR, 0, 128, 255, 0, 0, 0));
		send_beat(make_beat(OP_COLOR, 32'h8000_0000, 32'h7FFF_FFFF, 1, 0, 0, 0));
		send_beat(make_beat(OP_COLOR, -1, 32'h7FFF_FFFF, 32'h8000_0000, 8'hFF, 3'd7, 24'hFFFFFF));
		send_beat(make_beat(OP_NONE, -1, -1, -1, 8'hFF, 3'd7, 24'hFFFFFF));
		send_beat(make_beat(OP_NONE, 0, 0, 0, 0, 0, 0));
		send_beat(make_beat(OP_TABLE, 0, 0, 0, 8'd0, 3'd7, 24'hFFFFFF));
		drain();
		// highlight on, zero span taken as one
		set_window(32'd100, 32'd0, 16'd256, 16'd256, 16'd256, 1'b1, 24'h00FF00, 3'd7);
		send_beat(make_beat(OP_MONO, 100, 0, 0, 0, 0, 0));
		send_beat(make_beat(OP_MONO, 101, 0, 0, 0, 0, 0));
		send_beat(make_beat(OP_COLOR, 99, 100, 101, 0, 0, 0));
		send_beat(make_beat(OP_COLOR, 100, 100, 100, 0, 0, 0));
		drain();

		for (int phase = 0; phase < 8; phase++) begin
			case (phase)
				0: set_window(0, 255, 256, 256, 256, 0, 24'hFF0000, 0);
				1: set_window(-1000, 2000, 128, 256, 512, 1, 24'h00FF00, 7);
				2: set_window(32'h8000_0000, 32'h7FFF_FFFF, 16'hFFFF, 0, 1, 1,
					24'hFFFFFF, 7);
				3: set_window(32'h7FFF_FFFF, 1, 256, 256, 256, 0, 24'h000000, 0);
				4: set_window($urandom_range(0, 2097152) - 1048576, $urandom_range(1, 65536),
					$urandom, $urandom, $urandom, $urandom, $urandom, loaded_palette());
				5: set_window($urandom_range(0, 2000) - 1000, 0, 256, $urandom, 256, 1,
					24'h000000, loaded_palette());
				default: set_window($urandom, $urandom_range(1, 32'h7FFF_FFFF), $urandom,
					$urandom, $urandom, $urandom, $urandom, loaded_palette());
			endcase
			calm = (phase == 4);
			for (int n = 0; n < 120; n++) begin
				// hold the receiver off while beats keep coming so the pipe backs up
				if (phase == 1 && n == 20) hold_req = 1'b1;
				send_beat(random_beat());
			end
			calm = 1'b0;
			drain();
		end

		while (pending != 0) @(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
		if (errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
